>>> sv/pct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page commit tracker package
// Shared widths, codes and the structures passed between the tracker blocks.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int PAGE_W        = 13;
  localparam int SIZE_W        = 33;
  localparam int BYTE_W        = 45;
  localparam int CFG_IDX_W     = 1;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 96;
  localparam int OUT_TUSER_W   = 2;

  localparam int PAGES_DEF     = 4096;
  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_RANGE_DEF = 64;

  localparam logic [SIZE_W-1:0] PAGE_SIZE_RST = SIZE_W'(4096);

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STRATEGY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAGE_SIZE = 1'b1;

  typedef enum logic [1:0] {
    STRAT_EXACT      = 2'd0,
    STRAT_AGGRESSIVE = 2'd1,
    STRAT_WATERMARK  = 2'd2,
    STRAT_BYPASS     = 2'd3
  } strategy_e;

  typedef enum logic [1:0] {
    JOB_ERROR = 2'd0,
    JOB_EXACT = 2'd1,
    JOB_AGGR  = 2'd2,
    JOB_WMARK = 2'd3
  } job_kind_e;

  typedef struct packed {
    job_kind_e         kind;
    logic              op;
    logic [PAGE_W-1:0] s;
    logic [PAGE_W-1:0] e;
  } job_t;

  typedef struct packed {
    logic              cmd;
    logic              err;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] count;
  } region_t;

  typedef struct packed {
    logic    emit;
    logic    fin;
    region_t region;
  } emit_t;

endpackage
`default_nettype wire

>>> sv/page_commit_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page commit tracker
// Turns commit and decommit requests over page ranges into region commands.
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared one word a cycle, all WORDS words (64 with
// the default sizes), while s_axis_tready stays low; configuration writes
// are taken throughout. A request with a bad range, or in watermark mode,
// passes through ST_ONE and then ST_FIN in the back end. An exact request
// first finds its first word in ST_DIV0 and ST_DIV1, then reads and loads
// each bitmap word that it touches and walks its pages one at a time in
// ST_BIT; an aggressive commit reads each word and writes it back full.
// Up to two requests wait in the queue meanwhile, and the last region of a
// request is held one step so that it can carry tlast. Bypass requests
// with a good range cause no word on the output.
module page_commit_tracker_core import pct_pkg::*; #(
  parameter int PAGES     = PAGES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int MAX_RANGE = MAX_RANGE_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [SIZE_W-1:0]      cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: range start [12:0], range end [25:13]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation [0]
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: byte_offset [44:0], byte_length [89:45]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // tuser: command [0], error [1]
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
  output logic                        m_axis_tlast
);

  strategy_e         strategy_q;
  logic [SIZE_W-1:0] page_size_q;

  logic  push;
  job_t  job_in;
  job_t  job_out;
  logic  q_valid;
  logic  q_full;
  logic  q_pop;
  logic  clearing;
  logic  push_ok;
  emit_t req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q  <= STRAT_EXACT;
      page_size_q <= PAGE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_STRATEGY:  strategy_q  <= strategy_e'(cfg_wdata_i[1:0]);
        default:           page_size_q <= cfg_wdata_i;
      endcase
    end
  end

  pct_front #(
    .PAGES     (PAGES),
    .MAX_RANGE (MAX_RANGE)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .strategy_i    (strategy_q),
    .full_i        (q_full),
    .clearing_i    (clearing),
    .push_o        (push),
    .job_o         (job_in)
  );

  pct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (q_pop),
    .job_o   (job_out),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  pct_back #(
    .PAGES     (PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .job_i      (job_out),
    .q_pop_o    (q_pop),
    .push_ok_i  (push_ok),
    .req_o      (req),
    .clearing_o (clearing)
  );

  pct_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .page_size_i   (page_size_q),
    .push_ok_o     (push_ok),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

>>> sv/pct_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page commit tracker front end
// Takes request words, checks the range and sorts them into jobs.
// ----------------------------------------------------------------------------
module pct_front import pct_pkg::*; #(
  parameter int PAGES     = PAGES_DEF,
  parameter int MAX_RANGE = MAX_RANGE_DEF
) (
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                  s_axis_tuser,
  input  wire strategy_e             strategy_i,
  input  wire logic                  full_i,
  input  wire logic                  clearing_i,
  output logic                       push_o,
  output job_t                       job_o
);

  localparam int CW = ($clog2(PAGES + 1) > PAGE_W) ? $clog2(PAGES + 1) : PAGE_W;

  logic [PAGE_W-1:0] s;
  logic [PAGE_W-1:0] e;
  logic [PAGE_W-1:0] span;
  logic              bad;
  logic              drop;

  assign s    = s_axis_tdata[PAGE_W-1:0];
  assign e    = s_axis_tdata[2*PAGE_W-1:PAGE_W];
  assign span = e - s;
  assign bad  = (s > e) || (CW'(e) > CW'(PAGES)) || (span > PAGE_W'(MAX_RANGE));

  always_comb begin
    job_o.op = s_axis_tuser;
    job_o.s  = s;
    job_o.e  = e;
    if (bad) begin
      job_o.kind = JOB_ERROR;
    end else begin
      unique case (strategy_i)
        STRAT_EXACT:      job_o.kind = JOB_EXACT;
        STRAT_AGGRESSIVE: job_o.kind = s_axis_tuser ? JOB_EXACT : JOB_AGGR;
        STRAT_WATERMARK:  job_o.kind = JOB_WMARK;
        default:          job_o.kind = JOB_EXACT;
      endcase
    end
  end

  assign drop          = !bad && (strategy_i == STRAT_BYPASS);
  assign s_axis_tready = !full_i && !clearing_i;
  assign push_o        = s_axis_tvalid && s_axis_tready && !drop;

endmodule
`default_nettype wire

>>> sv/pct_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page commit tracker job queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pct_queue import pct_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      valid_o,
  output logic      full_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign job_o   = slot_q[rd_ptr_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule
`default_nettype wire

>>> sv/pct_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page commit tracker back end
// Walks each job over the commit bitmap and the watermark and issues regions.
// ----------------------------------------------------------------------------
module pct_back import pct_pkg::*; #(
  parameter int PAGES     = PAGES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire job_t job_i,
  output logic      q_pop_o,
  input  wire logic push_ok_i,
  output emit_t     req_o,
  output logic      clearing_o
);

  localparam int WORDS = (PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WW    = $clog2(WORDS + 1);
  localparam int PW    = $clog2(PAGES + 1);
  localparam int BW    = $clog2(WORD_BITS);
  localparam int KSH   = PW + 1;
  localparam logic [KSH-1:0]       RECIP_V   = KSH'((1 << KSH) / WORD_BITS);
  localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_CLEAR = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd1;
  localparam logic [ST_W-1:0] ST_DIV0  = 4'd2;
  localparam logic [ST_W-1:0] ST_DIV1  = 4'd3;
  localparam logic [ST_W-1:0] ST_RD    = 4'd4;
  localparam logic [ST_W-1:0] ST_LOAD  = 4'd5;
  localparam logic [ST_W-1:0] ST_BIT   = 4'd6;
  localparam logic [ST_W-1:0] ST_AGG   = 4'd7;
  localparam logic [ST_W-1:0] ST_ONE   = 4'd8;
  localparam logic [ST_W-1:0] ST_FIN   = 4'd9;

  logic [WORD_BITS-1:0] mem_q [WORDS];
  logic [WORD_BITS-1:0] rdata_q;

  logic [ST_W-1:0]      state_q, state_d;
  job_t                 job_q, job_d;
  logic [PW-1:0]        wm_q, wm_d;
  logic [WW-1:0]        w_q, w_d;
  logic [BW-1:0]        b_q, b_d;
  logic [PW-1:0]        p_q, p_d;
  logic [PW-1:0]        base_q, base_d;
  logic [WW-1:0]        qest_q, qest_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [AW-1:0]        clr_q, clr_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;

  logic [PW-1:0]        js;
  logic [PW-1:0]        je;
  logic [PW+KSH-1:0]    prod;
  logic [PW-1:0]        qb;
  logic [PW-1:0]        rem;
  logic [PW-1:0]        rem_c;
  logic                 corr;
  logic                 want;
  logic [WORD_BITS-1:0] word_n;
  logic                 last_page;
  logic                 word_end;
  logic [PW:0]          base_n;

  assign js        = PW'(job_q.s);
  assign je        = PW'(job_q.e);
  assign prod      = {{KSH{1'b0}}, js} * {{PW{1'b0}}, RECIP_V};
  assign qb        = PW'(qest_q * WORD_BITS);
  assign rem       = js - qb;
  assign corr      = (rem >= PW'(WORD_BITS));
  assign rem_c     = corr ? (rem - PW'(WORD_BITS)) : rem;
  assign want      = !job_q.op;
  assign last_page = (({1'b0, p_q} + (PW+1)'(1)) == {1'b0, je});
  assign word_end  = (b_q == BW'(WORD_BITS - 1));
  assign base_n    = {1'b0, base_q} + (PW+1)'(WORD_BITS);

  always_comb begin
    word_n       = word_q;
    word_n[b_q]  = want;
  end

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    wm_d       = wm_q;
    w_d        = w_q;
    b_d        = b_q;
    p_d        = p_q;
    base_d     = base_q;
    qest_d     = qest_q;
    word_d     = word_q;
    clr_d      = clr_q;
    mem_we     = 1'b0;
    mem_waddr  = w_q[AW-1:0];
    mem_wdata  = word_n;
    mem_re     = 1'b0;
    q_pop_o    = 1'b0;
    req_o      = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          job_d   = job_i;
          unique case (job_i.kind)
            JOB_EXACT: state_d = (job_i.s == job_i.e) ? ST_IDLE : ST_DIV0;
            JOB_AGGR:  state_d = ST_DIV0;
            default:   state_d = ST_ONE;
          endcase
        end
      end
      ST_DIV0: begin
        qest_d  = prod[KSH +: WW];
        state_d = ST_DIV1;
      end
      ST_DIV1: begin
        w_d    = qest_q + WW'(corr);
        b_d    = BW'(rem_c);
        base_d = js - rem_c;
        p_d    = js;
        if (job_q.kind == JOB_AGGR) begin
          state_d = ((js - rem_c) < je) ? ST_RD : ST_FIN;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = (job_q.kind == JOB_AGGR) ? ST_AGG : ST_LOAD;
      end
      ST_LOAD: begin
        word_d  = rdata_q;
        state_d = ST_BIT;
      end
      ST_BIT: begin
        if (push_ok_i) begin
          if (word_q[b_q] != want) begin
            req_o.emit         = 1'b1;
            req_o.region.cmd   = job_q.op;
            req_o.region.page  = PAGE_W'(p_q);
            req_o.region.count = PAGE_W'(1);
          end
          word_d = word_n;
          p_d    = p_q + PW'(1);
          b_d    = b_q + BW'(1);
          if (last_page || word_end) begin
            mem_we = 1'b1;
          end
          if (last_page) begin
            state_d = ST_FIN;
          end else if (word_end) begin
            w_d     = w_q + WW'(1);
            b_d     = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_AGG: begin
        if (push_ok_i) begin
          if (rdata_q != FULL_WORD) begin
            req_o.emit         = 1'b1;
            req_o.region.page  = PAGE_W'(base_q);
            req_o.region.count = PAGE_W'(WORD_BITS);
          end
          mem_we    = 1'b1;
          mem_wdata = FULL_WORD;
          w_d       = w_q + WW'(1);
          base_d    = base_n[PW-1:0];
          state_d   = (base_n < {1'b0, je}) ? ST_RD : ST_FIN;
        end
      end
      ST_ONE: begin
        if (push_ok_i) begin
          if (job_q.kind == JOB_ERROR) begin
            req_o.emit       = 1'b1;
            req_o.region.cmd = job_q.op;
            req_o.region.err = 1'b1;
          end else if (!job_q.op) begin
            if (je > wm_q) begin
              req_o.emit         = 1'b1;
              req_o.region.page  = PAGE_W'(wm_q);
              req_o.region.count = PAGE_W'(je - wm_q);
              wm_d               = je;
            end
          end else if (wm_q != '0) begin
            req_o.emit         = 1'b1;
            req_o.region.cmd   = 1'b1;
            req_o.region.count = PAGE_W'(wm_q);
            wm_d               = '0;
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (push_ok_i) begin
          req_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign clearing_o = (state_q == ST_CLEAR);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[w_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    w_q    <= w_d;
    b_q    <= b_d;
    p_q    <= p_d;
    base_q <= base_d;
    qest_q <= qest_d;
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      wm_q    <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      wm_q    <= wm_d;
      clr_q   <= clr_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(req_o.emit && req_o.fin))
    else $error("region issued and job closed in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_o.emit || req_o.fin) |-> push_ok_i)
    else $error("region issued while the output side cannot take it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (int'(mem_waddr) < WORDS))
    else $error("bitmap write beyond the last word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BIT) |-> (p_q < je))
    else $error("page walk ran past the end of the range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_LOAD || state_q == ST_AGG))
    else $error("bitmap read not followed by its use");

endmodule
`default_nettype wire

>>> sv/pct_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Page commit tracker output stage
// Holds one region back to mark the last one, scales it to bytes and drives it.
// ----------------------------------------------------------------------------
module pct_out import pct_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire emit_t                   req_i,
  input  wire logic [SIZE_W-1:0]       page_size_i,
  output logic                         push_ok_o,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic [OUT_TUSER_W-1:0]       m_axis_tuser,
  output logic                         m_axis_tlast
);

  localparam int SPLIT = SIZE_W - 1;

  function automatic logic [BYTE_W-1:0] scale(logic [PAGE_W-1:0] n, logic [SIZE_W-1:0] ps);
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    lo = {{SPLIT{1'b0}}, n} * {{PAGE_W{1'b0}}, ps[SPLIT-1:0]};
    hi = ps[SPLIT] ? {n, {SPLIT{1'b0}}} : '0;
    return lo + hi;
  endfunction

  logic              pend_v_q;
  region_t           pend_q;
  logic              a_v_q;
  region_t           a_q;
  logic              a_last_q;
  logic              o_v_q;
  logic [BYTE_W-1:0] o_off_q;
  logic [BYTE_W-1:0] o_len_q;
  logic              o_cmd_q;
  logic              o_err_q;
  logic              o_last_q;

  logic              out_load;
  logic              a_ready;
  logic              a_load;

  assign out_load  = a_v_q && (!o_v_q || m_axis_tready);
  assign a_ready   = !a_v_q || out_load;
  assign push_ok_o = !pend_v_q || a_ready;
  assign a_load    = pend_v_q && (req_i.emit || req_i.fin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      a_v_q    <= 1'b0;
      o_v_q    <= 1'b0;
    end else begin
      if (req_i.emit) begin
        pend_v_q <= 1'b1;
      end else if (req_i.fin) begin
        pend_v_q <= 1'b0;
      end
      if (a_load) begin
        a_v_q <= 1'b1;
      end else if (out_load) begin
        a_v_q <= 1'b0;
      end
      if (out_load) begin
        o_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.emit) begin
      pend_q <= req_i.region;
    end
    if (a_load) begin
      a_q      <= pend_q;
      a_last_q <= req_i.fin;
    end
    if (out_load) begin
      o_off_q  <= scale(a_q.page, page_size_i);
      o_len_q  <= scale(a_q.count, page_size_i);
      o_cmd_q  <= a_q.cmd;
      o_err_q  <= a_q.err;
      o_last_q <= a_last_q;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2*BYTE_W){1'b0}}, o_len_q, o_off_q};
  assign m_axis_tuser  = {o_err_q, o_cmd_q};
  assign m_axis_tlast  = o_last_q;

endmodule
`default_nettype wire
